### rtl/gsrf_pkg.sv
// ----------------------------------------------------------------------------
// gsrf_pkg - scalar register file shared definitions
// Widths, request kinds, default special register numbers, reserved-hole
// decode and the reset contents of the register store.
// ----------------------------------------------------------------------------
`default_nettype none

package gsrf_pkg;

	localparam int DATA_W   = 32;
	localparam int IDX_W    = 8;
	localparam int LANE_W   = 6;
	localparam int DEPTH    = 256;
	localparam int NUM_SLOT = 6;

	localparam int VCC_INDEX_DEF   = 106;
	localparam int EXEC_INDEX_DEF  = 126;
	localparam int VCCZ_INDEX_DEF  = 251;
	localparam int EXECZ_INDEX_DEF = 252;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	// slot order inside the special register block
	localparam int SLOT_VCC_LO  = 0;
	localparam int SLOT_VCC_HI  = 1;
	localparam int SLOT_EXEC_LO = 2;
	localparam int SLOT_EXEC_HI = 3;
	localparam int SLOT_VCCZ    = 4;
	localparam int SLOT_EXECZ   = 5;

	typedef struct packed {
		logic              slot_hit;
		logic [DATA_W-1:0] slot_value;
		logic              derived;
		logic              derived_flag;
		logic              lane_active;
	} spec_t;

	function automatic logic is_hole(input logic [IDX_W-1:0] idx);
		logic hole;
		hole = 1'b0;
		if (idx == 8'd104 || idx == 8'd105 || idx == 8'd125 || idx == 8'd254)
			hole = 1'b1;
		if (idx >= 8'd209 && idx <= 8'd239)
			hole = 1'b1;
		if (idx >= 8'd248 && idx <= 8'd250)
			hole = 1'b1;
		return hole;
	endfunction

	function automatic logic [DATA_W-1:0] reset_value(input logic [IDX_W-1:0] idx);
		logic [DATA_W-1:0] v;
		logic [IDX_W-1:0]  off;
		v   = '0;
		off = '0;
		if (idx >= 8'd128 && idx <= 8'd192) begin
			off = idx - 8'd128;
			v   = {{(DATA_W-IDX_W){1'b0}}, off};
		end else if (idx >= 8'd193 && idx <= 8'd208) begin
			off = idx - 8'd193;
			v   = 32'hFFFF_FFFF - {{(DATA_W-IDX_W){1'b0}}, off};
		end else if (idx >= 8'd240 && idx <= 8'd247) begin
			case (idx[2:0])
				3'd0: v = 32'h3F00_0000;
				3'd1: v = 32'hBF00_0000;
				3'd2: v = 32'h3F80_0000;
				3'd3: v = 32'hBF80_0000;
				3'd4: v = 32'h4000_0000;
				3'd5: v = 32'hC000_0000;
				3'd6: v = 32'h4080_0000;
				3'd7: v = 32'hC080_0000;
				default: v = '0;
			endcase
		end
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/gsrf_if.sv
// ----------------------------------------------------------------------------
// gsrf_req_if / gsrf_rsp_if - request and response channels
// Valid/ready channels carrying one register access and its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsrf_req_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [gsrf_pkg::IDX_W-1:0]      register_index;
	logic [gsrf_pkg::DATA_W-1:0]     write_value;
	logic [gsrf_pkg::LANE_W-1:0]     lane;

	modport source (output valid, kind, register_index, write_value, lane, input ready);
	modport sink   (input valid, kind, register_index, write_value, lane, output ready);
endinterface

interface gsrf_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [gsrf_pkg::DATA_W-1:0]     read_value;
	logic                            lane_active;
	logic                            illegal;

	modport source (output valid, read_value, lane_active, illegal, input ready);
	modport sink   (input valid, read_value, lane_active, illegal, output ready);
endinterface

`default_nettype wire

### rtl/gsrf_mem.sv
// ----------------------------------------------------------------------------
// gsrf_mem - main register storage
// 256 x 32 synchronous memory with registered read data; per-entry valid
// bits make unwritten entries read as their reset contents.
// ----------------------------------------------------------------------------
`default_nettype none

module gsrf_mem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [gsrf_pkg::IDX_W-1:0]    rd_idx,
	input  wire logic                          wr_en,
	input  wire logic [gsrf_pkg::IDX_W-1:0]    wr_idx,
	input  wire logic [gsrf_pkg::DATA_W-1:0]   wr_data,
	output logic      [gsrf_pkg::DATA_W-1:0]   rd_data
);

	logic [gsrf_pkg::DATA_W-1:0] mem [gsrf_pkg::DEPTH];
	logic [gsrf_pkg::DEPTH-1:0]  valid_q;
	logic [gsrf_pkg::DATA_W-1:0] rdata_q;
	logic [gsrf_pkg::DATA_W-1:0] rst_val_q;
	logic                        rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		if (rd_en) begin
			rdata_q   <= mem[rd_idx];
			rst_val_q <= gsrf_pkg::reset_value(rd_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_idx] <= 1'b1;
			if (rd_en)
				rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd_data = rd_valid_q ? rdata_q : rst_val_q;

endmodule

`default_nettype wire

### rtl/gsrf_special.sv
// ----------------------------------------------------------------------------
// gsrf_special - VCC, EXEC, VCCZ and EXECZ shadow entries
// Flip-flop copies of the special registers: serve their reads, the lane
// exec bit and the zero flags, and apply the zero-flag refresh on writes.
// ----------------------------------------------------------------------------
`default_nettype none

module gsrf_special #(
	parameter int VCC_INDEX   = gsrf_pkg::VCC_INDEX_DEF,
	parameter int EXEC_INDEX  = gsrf_pkg::EXEC_INDEX_DEF,
	parameter int VCCZ_INDEX  = gsrf_pkg::VCCZ_INDEX_DEF,
	parameter int EXECZ_INDEX = gsrf_pkg::EXECZ_INDEX_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          upd,
	input  wire logic                          wr,
	input  wire logic [gsrf_pkg::IDX_W-1:0]    idx,
	input  wire logic [gsrf_pkg::DATA_W-1:0]   wdata,
	input  wire logic [gsrf_pkg::LANE_W-1:0]   lane,
	output gsrf_pkg::spec_t                    info
);

	localparam logic [gsrf_pkg::IDX_W-1:0] VccIdx   = gsrf_pkg::IDX_W'(VCC_INDEX);
	localparam logic [gsrf_pkg::IDX_W-1:0] VccHiIdx = gsrf_pkg::IDX_W'(VCC_INDEX + 1);
	localparam logic [gsrf_pkg::IDX_W-1:0] ExecIdx  = gsrf_pkg::IDX_W'(EXEC_INDEX);
	localparam logic [gsrf_pkg::IDX_W-1:0] ExecHiIdx = gsrf_pkg::IDX_W'(EXEC_INDEX + 1);
	localparam logic [gsrf_pkg::IDX_W-1:0] VcczIdx  = gsrf_pkg::IDX_W'(VCCZ_INDEX);
	localparam logic [gsrf_pkg::IDX_W-1:0] ExeczIdx = gsrf_pkg::IDX_W'(EXECZ_INDEX);

	logic [gsrf_pkg::IDX_W-1:0]  slot_idx [gsrf_pkg::NUM_SLOT];
	logic [gsrf_pkg::DATA_W-1:0] slot_q   [gsrf_pkg::NUM_SLOT];
	logic [gsrf_pkg::DATA_W-1:0] step1    [gsrf_pkg::NUM_SLOT];
	logic [gsrf_pkg::DATA_W-1:0] step2    [gsrf_pkg::NUM_SLOT];
	logic [gsrf_pkg::DATA_W-1:0] step3    [gsrf_pkg::NUM_SLOT];
	logic                        trig_v;
	logic                        trig_e;
	logic                        pz_v;
	logic                        pz_e;
	logic [gsrf_pkg::DATA_W-1:0] exec_word;

	always_comb begin
		slot_idx[gsrf_pkg::SLOT_VCC_LO]  = VccIdx;
		slot_idx[gsrf_pkg::SLOT_VCC_HI]  = VccHiIdx;
		slot_idx[gsrf_pkg::SLOT_EXEC_LO] = ExecIdx;
		slot_idx[gsrf_pkg::SLOT_EXEC_HI] = ExecHiIdx;
		slot_idx[gsrf_pkg::SLOT_VCCZ]    = VcczIdx;
		slot_idx[gsrf_pkg::SLOT_EXECZ]   = ExeczIdx;
	end

	// apply the register write, then the VCCZ refresh, then the EXECZ refresh
	always_comb begin
		trig_v = wr && (idx == VccIdx || idx == VccHiIdx);
		trig_e = wr && (idx == ExecIdx || idx == ExecHiIdx);
		for (int i = 0; i < gsrf_pkg::NUM_SLOT; i++)
			step1[i] = (wr && slot_idx[i] == idx) ? wdata : slot_q[i];
		pz_v = (step1[gsrf_pkg::SLOT_VCC_LO] == '0) && (step1[gsrf_pkg::SLOT_VCC_HI] == '0);
		for (int i = 0; i < gsrf_pkg::NUM_SLOT; i++)
			step2[i] = (trig_v && slot_idx[i] == VcczIdx) ?
				{{(gsrf_pkg::DATA_W-1){1'b0}}, pz_v} : step1[i];
		pz_e = (step2[gsrf_pkg::SLOT_EXEC_LO] == '0) && (step2[gsrf_pkg::SLOT_EXEC_HI] == '0);
		for (int i = 0; i < gsrf_pkg::NUM_SLOT; i++)
			step3[i] = (trig_e && slot_idx[i] == ExeczIdx) ?
				{{(gsrf_pkg::DATA_W-1){1'b0}}, pz_e} : step2[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gsrf_pkg::NUM_SLOT; i++)
				slot_q[i] <= gsrf_pkg::reset_value(slot_idx[i]);
		end else if (upd) begin
			for (int i = 0; i < gsrf_pkg::NUM_SLOT; i++)
				slot_q[i] <= step3[i];
		end
	end

	always_comb begin
		info.slot_hit   = 1'b0;
		info.slot_value = '0;
		for (int i = 0; i < gsrf_pkg::NUM_SLOT; i++) begin
			if (slot_idx[i] == idx) begin
				info.slot_hit   = 1'b1;
				info.slot_value = slot_q[i];
			end
		end
		info.derived      = (idx == VcczIdx) || (idx == ExeczIdx);
		if (idx == VcczIdx)
			info.derived_flag = (slot_q[gsrf_pkg::SLOT_VCC_LO] == '0) &&
				(slot_q[gsrf_pkg::SLOT_VCC_HI] == '0);
		else
			info.derived_flag = (slot_q[gsrf_pkg::SLOT_EXEC_LO] == '0) &&
				(slot_q[gsrf_pkg::SLOT_EXEC_HI] == '0);
		exec_word = lane[gsrf_pkg::LANE_W-1] ? slot_q[gsrf_pkg::SLOT_EXEC_HI] :
			slot_q[gsrf_pkg::SLOT_EXEC_LO];
		info.lane_active = exec_word[lane[gsrf_pkg::LANE_W-2:0]];
	end

endmodule

`default_nettype wire

### rtl/gpu_scalar_register_file.sv
// ----------------------------------------------------------------------------
// gpu_scalar_register_file - wavefront scalar register file
// 256 x 32 scalar registers with derived VCCZ/EXECZ flags, exec-mask lane
// lookup and reserved-hole detection.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+---------------------------------------------------
//  req     | in  | kind, register_index, write_value, lane
//  rsp     | out | read_value, lane_active, illegal
//
//  One request per cycle unless the receiver stalls; the result appears in
//  the cycle after acceptance, as the register memory read is registered.
//  req.ready is high while the result register is empty or being taken.
//  Reset is immediate: per-entry valid bits supply the inline constants,
//  so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module gpu_scalar_register_file #(
	parameter int VCC_INDEX   = gsrf_pkg::VCC_INDEX_DEF,
	parameter int EXEC_INDEX  = gsrf_pkg::EXEC_INDEX_DEF,
	parameter int VCCZ_INDEX  = gsrf_pkg::VCCZ_INDEX_DEF,
	parameter int EXECZ_INDEX = gsrf_pkg::EXECZ_INDEX_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	gsrf_req_if.sink   req,
	gsrf_rsp_if.source rsp
);

	logic                        accept;
	logic                        bad;
	logic                        wr;
	logic                        valid_q;
	logic                        write_s1;
	logic                        bad_s1;
	gsrf_pkg::spec_t             spec;
	gsrf_pkg::spec_t             spec_s1;
	logic [gsrf_pkg::DATA_W-1:0] mem_data;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign bad       = gsrf_pkg::is_hole(req.register_index);
	assign wr        = (req.kind == gsrf_pkg::KIND_WRITE) && !bad;

	gsrf_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (req.register_index),
		.wr_en   (accept && wr),
		.wr_idx  (req.register_index),
		.wr_data (req.write_value),
		.rd_data (mem_data)
	);

	gsrf_special #(
		.VCC_INDEX   (VCC_INDEX),
		.EXEC_INDEX  (EXEC_INDEX),
		.VCCZ_INDEX  (VCCZ_INDEX),
		.EXECZ_INDEX (EXECZ_INDEX)
	) u_special (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (accept),
		.wr     (wr),
		.idx    (req.register_index),
		.wdata  (req.write_value),
		.lane   (req.lane),
		.info   (spec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			write_s1 <= (req.kind == gsrf_pkg::KIND_WRITE);
			bad_s1   <= bad;
			spec_s1  <= spec;
		end
	end

	always_comb begin
		if (write_s1 || bad_s1)
			rsp.read_value = '0;
		else if (spec_s1.derived)
			rsp.read_value = {{(gsrf_pkg::DATA_W-1){1'b0}}, spec_s1.derived_flag};
		else if (spec_s1.slot_hit)
			rsp.read_value = spec_s1.slot_value;
		else
			rsp.read_value = mem_data;
	end

	assign rsp.valid       = valid_q;
	assign rsp.lane_active = spec_s1.lane_active;
	assign rsp.illegal     = bad_s1;

endmodule

`default_nettype wire

### dv/gpu_scalar_register_file_tb.sv
// ----------------------------------------------------------------------------
// gpu_scalar_register_file_tb - scalar register file testbench
// Drives read and write requests into the register file through a queued
// driver and checks every result against a predictor that keeps its own copy
// of the 256-entry store, with derived VCCZ/EXECZ flags, exec lane lookup and
// reserved-hole decode. A directed pass covers the constants, the holes and
// the special registers; random phases then run with and without idling and
// with a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module gpu_scalar_register_file_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gsrf_pkg::*;

	localparam logic [IDX_W-1:0] VCC_LO   = IDX_W'(VCC_INDEX_DEF);
	localparam logic [IDX_W-1:0] VCC_HI   = IDX_W'(VCC_INDEX_DEF + 1);
	localparam logic [IDX_W-1:0] EXEC_LO  = IDX_W'(EXEC_INDEX_DEF);
	localparam logic [IDX_W-1:0] EXEC_HI  = IDX_W'(EXEC_INDEX_DEF + 1);
	localparam logic [IDX_W-1:0] VCCZ_IX  = IDX_W'(VCCZ_INDEX_DEF);
	localparam logic [IDX_W-1:0] EXECZ_IX = IDX_W'(EXECZ_INDEX_DEF);

	typedef struct {
		kind_t              kind;
		logic [IDX_W-1:0]   register_index;
		logic [DATA_W-1:0]  write_value;
		logic [LANE_W-1:0]  lane;
	} access_t;

	typedef struct {
		logic [DATA_W-1:0] read_value;
		logic              lane_active;
		logic              illegal;
	} access_result_t;

	logic clk;
	logic arst_n;

	gsrf_req_if req_ch ();
	gsrf_rsp_if rsp_ch ();

	gpu_scalar_register_file u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [DATA_W-1:0] sreg [DEPTH];
	access_t           access_q [$];
	access_result_t    result_q [$];
	int unsigned       tx_idle_pct;
	int unsigned       rx_stall_pct;
	int unsigned       rx_hold_left;
	int unsigned       err_cnt;
	logic              req_fire;

	function automatic logic is_reserved(input logic [IDX_W-1:0] idx);
		return idx == 8'd104 || idx == 8'd105 || idx == 8'd125 || idx == 8'd254 ||
			(idx >= 8'd209 && idx <= 8'd239) || (idx >= 8'd248 && idx <= 8'd250);
	endfunction

	function automatic logic pair_clear(input logic [IDX_W-1:0] base);
		return sreg[base] == '0 && sreg[IDX_W'(base + 8'd1)] == '0;
	endfunction

	function automatic access_result_t model_access(input access_t a);
		access_result_t    r;
		logic [DATA_W-1:0] word;
		word          = a.lane[LANE_W-1] ? sreg[EXEC_HI] : sreg[EXEC_LO];
		r.lane_active = word[a.lane[4:0]];
		r.illegal     = is_reserved(a.register_index);
		r.read_value  = '0;
		if (!r.illegal) begin
			if (a.kind == KIND_READ) begin
				if (a.register_index == VCCZ_IX)
					r.read_value = {31'b0, pair_clear(VCC_LO)};
				else if (a.register_index == EXECZ_IX)
					r.read_value = {31'b0, pair_clear(EXEC_LO)};
				else
					r.read_value = sreg[a.register_index];
			end else begin
				sreg[a.register_index] = a.write_value;
				if (a.register_index == VCC_LO || a.register_index == VCC_HI)
					sreg[VCCZ_IX] = {31'b0, pair_clear(VCC_LO)};
				if (a.register_index == EXEC_LO || a.register_index == EXEC_HI)
					sreg[EXECZ_IX] = {31'b0, pair_clear(EXEC_LO)};
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic queue_access(input kind_t k, input int idx, input logic [DATA_W-1:0] v,
			input int ln);
		access_t a;
		a.kind           = k;
		a.register_index = IDX_W'(idx);
		a.write_value    = v;
		a.lane           = LANE_W'(ln);
		access_q.push_back(a);
	endtask

	task automatic drain();
		while (access_q.size() != 0 || req_ch.valid || result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int unsigned tx_pct, input int unsigned rx_pct);
		int unsigned       sel;
		int                idx;
		logic [DATA_W-1:0] v;
		@(posedge clk);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(9);
			case (sel)
				5, 6, 7: begin
					case ($urandom_range(5))
						0: idx = int'(VCC_LO);
						1: idx = int'(VCC_HI);
						2: idx = int'(EXEC_LO);
						3: idx = int'(EXEC_HI);
						4: idx = int'(VCCZ_IX);
						default: idx = int'(EXECZ_IX);
					endcase
				end
				8: begin
					case ($urandom_range(3))
						0: idx = 104 + $urandom_range(1);
						1: idx = ($urandom_range(1) != 0) ? 125 : 254;
						2: idx = 209 + $urandom_range(30);
						default: idx = 248 + $urandom_range(2);
					endcase
				end
				9: idx = ($urandom_range(3) == 0) ? 240 + $urandom_range(7) : 128 + $urandom_range(80);
				default: idx = $urandom_range(255);
			endcase
			case ($urandom_range(7))
				0, 1: v = '0;
				2: v = '1;
				3: v = DATA_W'(1) << $urandom_range(31);
				default: v = $urandom;
			endcase
			queue_access(kind_t'($urandom_range(1)), idx, v, $urandom_range(63));
		end
		drain();
	endtask

	// driver: hold the request until taken, then offer the next one
	always @(negedge clk) begin : drv
		access_t a;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_fire) begin
			if (access_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				a = access_q.pop_front();
				req_ch.kind           <= a.kind;
				req_ch.register_index <= a.register_index;
				req_ch.write_value    <= a.write_value;
				req_ch.lane           <= a.lane;
				req_ch.valid          <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= arst_n && rx_hold_left == 0 && $urandom_range(99) >= rx_stall_pct;
	end

	always @(negedge clk) begin
		if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;
	end

	// monitor: check the result, then predict the request taken at this edge
	always @(posedge clk) begin : mon
		access_result_t want;
		access_t        a;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result", rsp_ch.read_value, '0);
				end else begin
					want = result_q.pop_front();
					if (rsp_ch.read_value !== want.read_value)
						report_mismatch("read_value", rsp_ch.read_value, want.read_value);
					if (rsp_ch.lane_active !== want.lane_active)
						report_mismatch("lane_active", DATA_W'(rsp_ch.lane_active),
							DATA_W'(want.lane_active));
					if (rsp_ch.illegal !== want.illegal)
						report_mismatch("illegal", DATA_W'(rsp_ch.illegal), DATA_W'(want.illegal));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				a.kind           = kind_t'(req_ch.kind);
				a.register_index = req_ch.register_index;
				a.write_value    = req_ch.write_value;
				a.lane           = req_ch.lane;
				result_q.push_back(model_access(a));
			end
		end
		req_fire <= arst_n && req_ch.valid && req_ch.ready;
	end

	initial begin
		clk                   = 1'b0;
		arst_n                = 1'b0;
		req_ch.valid          = 1'b0;
		req_ch.kind           = KIND_READ;
		req_ch.register_index = '0;
		req_ch.write_value    = '0;
		req_ch.lane           = '0;
		rsp_ch.ready          = 1'b0;
		req_fire              = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		err_cnt      = 0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold_left = 0;
		for (int i = 0; i < DEPTH; i++)
			sreg[i] = '0;
		for (int i = 128; i <= 192; i++)
			sreg[i] = DATA_W'(i - 128);
		for (int i = 193; i <= 208; i++)
			sreg[i] = 32'hFFFF_FFFF - DATA_W'(i - 193);
		sreg[240] = 32'h3F00_0000;
		sreg[241] = 32'hBF00_0000;
		sreg[242] = 32'h3F80_0000;
		sreg[243] = 32'hBF80_0000;
		sreg[244] = 32'h4000_0000;
		sreg[245] = 32'hC000_0000;
		sreg[246] = 32'h4080_0000;
		sreg[247] = 32'hC080_0000;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_access(KIND_READ,  0,             '0,            0);
		queue_access(KIND_READ,  128,           '1,            63);
		queue_access(KIND_READ,  192,           '0,            1);
		queue_access(KIND_READ,  193,           '0,            2);
		queue_access(KIND_READ,  208,           '0,            3);
		queue_access(KIND_READ,  240,           '0,            4);
		queue_access(KIND_READ,  247,           '0,            5);
		queue_access(KIND_READ,  int'(EXECZ_IX), '0,           0);
		queue_access(KIND_WRITE, int'(EXEC_LO), 32'h8000_0001, 0);
		queue_access(KIND_READ,  int'(EXECZ_IX), '0,           0);
		queue_access(KIND_WRITE, int'(EXEC_HI), 32'h8000_0000, 63);
		queue_access(KIND_READ,  int'(EXEC_HI), '0,            63);
		queue_access(KIND_WRITE, int'(EXEC_LO), '0,            31);
		queue_access(KIND_WRITE, int'(VCC_LO),  '1,            63);
		queue_access(KIND_READ,  int'(VCCZ_IX), '0,            32);
		queue_access(KIND_WRITE, int'(VCCZ_IX), 32'h1234_5678, 32);
		queue_access(KIND_READ,  int'(VCCZ_IX), '0,            32);
		queue_access(KIND_WRITE, int'(VCC_LO),  '0,            0);
		queue_access(KIND_READ,  104,           '0,            63);
		queue_access(KIND_WRITE, 105,           '1,            0);
		queue_access(KIND_READ,  254,           '0,            0);
		queue_access(KIND_WRITE, 250,           '1,            0);
		queue_access(KIND_READ,  209,           '0,            0);
		queue_access(KIND_WRITE, 128,           32'hDEAD_BEEF, 0);
		queue_access(KIND_READ,  128,           '0,            0);
		queue_access(KIND_WRITE, 255,           '1,            63);
		drain();

		run_phase(130, 0, 0);
		run_phase(130, 57, 0);
		run_phase(130, 0, 57);
		run_phase(100, 6, 6);

		// long receiver hold-off while the sender keeps offering
		@(posedge clk);
		rx_hold_left = 300;
		run_phase(40, 0, 0);

		while (result_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (result_q.size() != 0)
			report_mismatch("results left over", DATA_W'(result_q.size()), '0);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
